// ===== rtl/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== rtl/lfs_pkg.sv =====
`default_nettype none
package lfs_pkg;
    localparam int IMAGE_ROWS = 128;
    localparam int IMAGE_COLS = 256;

    localparam logic [2:0] CFG_PROP  = 3'd0;
    localparam logic [2:0] CFG_DERIV = 3'd1;
    localparam logic [2:0] CFG_STEER = 3'd2;
    localparam logic [2:0] CFG_LEFT  = 3'd3;
    localparam logic [2:0] CFG_RIGHT = 3'd4;

    typedef struct packed {
        logic store_in;
        logic rd_near;
        logic rd_far;
        logic lat_near;
        logic lat_far;
        logic calc_err;
        logic calc_pd;
        logic calc_fir;
        logic calc_out;
        logic load_out;
    } lfs_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/lfs_ram.sv =====
`default_nettype none
module lfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/lfs_ctrl.sv =====
`default_nettype none
module lfs_ctrl
    import lfs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_action,
    input  wire logic out_stall,
    output logic      in_stall,
    output logic      out_valid,
    output lfs_cmd_t  cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDN  = 4'd1;
    localparam logic [3:0] S_RDF  = 4'd2;
    localparam logic [3:0] S_LATN = 4'd3;
    localparam logic [3:0] S_LATF = 4'd4;
    localparam logic [3:0] S_ERR  = 4'd5;
    localparam logic [3:0] S_PD   = 4'd6;
    localparam logic [3:0] S_FIR  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_LOAD = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       acc;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign acc       = in_valid && !in_stall;

    // read data is registered, so each row is latched in the state after its read; near is latched before far is read
    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    cmd.store_in = 1'b1;
                    if (in_action)
                    begin
                        state_next = S_RDN;
                    end
                end
            end
            S_RDN:
            begin
                cmd.rd_near = 1'b1;
                state_next  = S_LATN;
            end
            S_LATN:
            begin
                cmd.lat_near = 1'b1;
                state_next   = S_RDF;
            end
            S_RDF:
            begin
                cmd.rd_far = 1'b1;
                state_next = S_LATF;
            end
            S_LATF:
            begin
                cmd.lat_far = 1'b1;
                state_next  = S_ERR;
            end
            S_ERR:
            begin
                cmd.calc_err = 1'b1;
                state_next   = S_PD;
            end
            S_PD:
            begin
                cmd.calc_pd = 1'b1;
                state_next  = S_FIR;
            end
            S_FIR:
            begin
                cmd.calc_fir = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                cmd.calc_out = 1'b1;
                state_next   = S_LOAD;
            end
            S_LOAD:
            begin
                if (!ov_next)
                begin
                    cmd.load_out = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

`include "assert_macros.svh"
    `ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.load_out, out_valid)
    `ASSERT_IMPLIES(a_load_free, clk, rst_n, cmd.load_out, !(ov_reg && out_stall))
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule
`default_nettype wire

// ===== rtl/lfs_datapath.sv =====
`default_nettype none
module lfs_datapath
    import lfs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  lfs_cmd_t                cmd,
    input  wire logic               cfg_valid,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               action,
    input  wire logic [6:0]         row,
    input  wire logic [7:0]         center_col,
    input  wire logic [9:0]         cruise_speed,
    input  wire logic [6:0]         aim_row,
    input  wire logic [6:0]         stop_line,
    output logic signed [10:0]      left_target,
    output logic signed [10:0]      right_target,
    output logic signed [17:0]      track_error,
    output logic signed [23:0]      turn_value
);
    localparam int AW = $clog2(IMAGE_ROWS);
    localparam int RW = AW + 2;
    localparam logic signed [RW-1:0] NEAR_Y = RW'(IMAGE_ROWS - 12);
    localparam logic signed [RW-1:0] AIM_MAX = RW'(IMAGE_ROWS - 15);
    localparam logic signed [RW-1:0] FAR_MAX = RW'(IMAGE_ROWS - 2);
    localparam logic signed [RW-1:0] ROWS_S = RW'(IMAGE_ROWS);
    localparam logic signed [11:0] MID = 12'(IMAGE_COLS / 2);

    logic signed [15:0] prop_reg, deriv_reg, steer_reg;
    logic [7:0]  lb_reg, rb_reg;
    logic [6:0]  aim_reg, stop_reg;
    logic [9:0]  base_reg;
    logic signed [17:0] last_e_reg, prev_e_reg, e_reg;
    logic signed [31:0] h0_reg, h1_reg, h2_reg, u_reg;
    logic signed [8:0]  nc_reg, fc_reg;
    logic signed [23:0] turn_reg;
    logic [6:0]  pct_reg;
    logic [8:0]  speed_reg;
    logic signed [10:0] lt_reg, rt_reg;
    logic [AW-1:0] raddr;
    logic [7:0]  rdata;
    logic        we;

    assign we = cmd.store_in && !action && (32'(row) < IMAGE_ROWS);

    lfs_ram #(.WIDTH(8), .DEPTH(IMAGE_ROWS)) u_ram (
        .clk(clk), .we(we), .waddr(AW'(row)), .wdata(center_col),
        .raddr(raddr), .rdata(rdata)
    );

    logic signed [RW-1:0] aim_s, far_y;
    logic signed [17:0] abs_last;
    always_comb
    begin
        abs_last = last_e_reg < 0 ? -last_e_reg : last_e_reg;
        aim_s = RW'(aim_reg);
        if ((abs_last >>> 8) > 18'sd20)
        begin
            aim_s = aim_s + RW'(20);
            if (aim_s > AIM_MAX) aim_s = AIM_MAX;
            if (aim_s < 0) aim_s = '0;
        end
        far_y = aim_s;
        if (far_y > FAR_MAX) far_y = FAR_MAX;
        if (stop_reg > 7'd5 && RW'(stop_reg) < ROWS_S)
        begin
            if (far_y < ROWS_S - RW'(stop_reg)) far_y = ROWS_S - RW'(stop_reg);
        end
        raddr = cmd.rd_near ? AW'(NEAR_Y) : AW'(far_y);
    end

    function automatic logic signed [8:0] bclamp(input logic [7:0] c,
                                                 input logic [7:0] l,
                                                 input logic [7:0] r);
        if (c <= l) return {1'b0, l};
        if (c >= r) return {1'b0, r};
        return {1'b0, c};
    endfunction

    // divide by 5 as multiply by 419431 >> 21, exact below 699050
    logic signed [23:0] num, anum, q5;
    logic [19:0] nx;
    logic [39:0] nq;
    logic signed [17:0] e_c;
    always_comb
    begin
        num = 24'sd512 * (24'(MID - 12'(nc_reg)) + 24'(MID - 12'(fc_reg)))
            + 24'sd1920 * 24'(nc_reg - fc_reg);
        anum = num < 0 ? -num : num;
        nx = 20'(anum + 24'sd2);
        nq = 40'(nx) * 40'd419431;
        q5 = 24'(nq >> 21);
        if (num < 0) q5 = -q5;
        if (q5 > 24'sd131071) e_c = 18'sd131071;
        else if (q5 < -24'sd131072) e_c = -18'sd131072;
        else e_c = 18'(q5);
        if (e_c > -18'sd512 && e_c < 18'sd512) e_c = '0;
    end

    logic signed [35:0] pp, pd;
    logic signed [37:0] psum, pabs, pq;
    logic signed [31:0] u_c;
    always_comb
    begin
        pp = prop_reg * e_reg;
        pd = deriv_reg * (19'(e_reg) - 19'(prev_e_reg));
        psum = 38'(pp) + 38'(pd);
        pabs = psum < 0 ? -psum : psum;
        pq = (pabs + 38'sd2048) >>> 12;
        if (psum < 0) pq = -pq;
        u_c = 32'(pq);
    end

    // |acc| stays below 2^29; divide by 100 as >> 2 then multiply by
    // 171798692 >> 32, exact below 2^30
    logic signed [39:0] acc, aabs, aq;
    logic [29:0] fx;
    logic [57:0] fq;
    logic signed [23:0] turn_c;
    always_comb
    begin
        acc = 40'sd80 * 40'(u_reg) + 40'sd10 * 40'(h0_reg)
            + 40'sd6 * 40'(h1_reg) + 40'sd4 * 40'(h2_reg);
        aabs = acc < 0 ? -acc : acc;
        fx = 30'((aabs + 40'sd50) >>> 2);
        fq = 58'(fx) * 58'd171798692;
        aq = 40'(fq >> 32);
        if (acc < 0) aq = -aq;
        if (aq > 40'sd8388607) turn_c = 24'sd8388607;
        else if (aq < -40'sd8388608) turn_c = -24'sd8388608;
        else turn_c = 24'(aq);
    end

    // speed percentage, divide by 37 as multiply by 3543 >> 17
    logic signed [17:0] ae;
    logic [9:0] a;
    logic [11:0] px;
    logic [23:0] pm;
    logic [6:0] pct_c;
    always_comb
    begin
        ae = e_reg < 0 ? -e_reg : e_reg;
        a = (ae >>> 8) > 18'sd45 ? 10'd45 : 10'(ae >>> 8);
        px = 12'(a - 10'd8) * 12'd70;
        pm = 24'(px) * 24'd3543;
        if (a <= 10'd8) pct_c = 7'd100;
        else if (a >= 10'd45) pct_c = 7'd30;
        else pct_c = 7'd100 - 7'(pm >> 17);
    end

    // divide by 100 as multiply by 167773 >> 24
    logic [16:0] bp, bq;
    logic [34:0] bm;
    logic [8:0] sp;
    always_comb
    begin
        bp = 17'(base_reg) * 17'(pct_reg);
        bm = 35'(bp) * 35'd167773;
        bq = 17'(bm >> 24);
        sp = bq < 17'd50 ? 9'd50 : (bq > 17'd300 ? 9'd300 : 9'(bq));
    end

    logic signed [39:0] dm, dq;
    logic signed [11:0] diff, lt, rt;
    always_comb
    begin
        dm = 40'(turn_reg) * 40'(steer_reg);
        dq = (dm < 0 ? -dm : dm) >>> 20;
        if (dm < 0) dq = -dq;
        diff = dq > 40'sd800 ? 12'sd800 : (dq < -40'sd800 ? -12'sd800 : 12'(dq));
        lt = 12'(speed_reg) - diff;
        rt = 12'(speed_reg) + diff;
        if (lt > 12'sd800) lt = 12'sd800;
        if (rt > 12'sd800) rt = 12'sd800;
        if (lt < -12'sd800) lt = -12'sd800;
        if (rt < -12'sd800) rt = -12'sd800;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_reg   <= 16'sd3277;
            deriv_reg  <= 16'sd41;
            steer_reg  <= 16'sd20480;
            lb_reg     <= 8'd0;
            rb_reg     <= 8'd255;
            last_e_reg <= '0;
            prev_e_reg <= '0;
            h0_reg     <= '0;
            h1_reg     <= '0;
            h2_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_PROP:  prop_reg  <= cfg_data;
                    CFG_DERIV: deriv_reg <= cfg_data;
                    CFG_STEER: steer_reg <= cfg_data;
                    CFG_LEFT:  lb_reg    <= cfg_data[7:0];
                    CFG_RIGHT: rb_reg    <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (cmd.calc_err)
            begin
                last_e_reg <= e_c;
            end
            if (cmd.calc_pd)
            begin
                prev_e_reg <= e_reg;
            end
            if (cmd.calc_fir)
            begin
                h0_reg <= u_reg;
                h1_reg <= h0_reg;
                h2_reg <= h1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_in)
        begin
            base_reg <= cruise_speed;
            aim_reg  <= aim_row;
            stop_reg <= stop_line;
        end
        if (cmd.lat_near) nc_reg <= bclamp(rdata, lb_reg, rb_reg);
        if (cmd.lat_far)  fc_reg <= bclamp(rdata, lb_reg, rb_reg);
        if (cmd.calc_err) e_reg <= e_c;
        if (cmd.calc_pd)
        begin
            u_reg   <= u_c;
            pct_reg <= pct_c;
        end
        if (cmd.calc_fir)
        begin
            turn_reg  <= turn_c;
            speed_reg <= sp;
        end
        if (cmd.calc_out)
        begin
            lt_reg <= 11'(lt);
            rt_reg <= 11'(rt);
        end
        if (cmd.load_out)
        begin
            left_target  <= lt_reg;
            right_target <= rt_reg;
            track_error  <= e_reg;
            turn_value   <= turn_reg;
        end
    end

`include "assert_macros.svh"
    `ASSERT_IMPLIES(a_dead, clk, rst_n, cmd.load_out, (e_reg == 0 || e_reg >= 512 || e_reg <= -512))
    `ASSERT_IMPLIES(a_wr_idle, clk, rst_n, we, !cmd.calc_err && !cmd.rd_far)
    `ASSERT_NEXT(a_err, clk, rst_n, cmd.calc_err, e_reg == last_e_reg)
endmodule
`default_nettype wire

// ===== rtl/line_follow_steering_pd.sv =====
// Line-following steering controller.
// Input channel (in_valid/in_stall): action 0 writes center_col into row,
// action 1 is a refresh using cruise_speed, aim_row and stop_line.
// A write gives no result; writes can follow back to back.
// A refresh steps through near row read, far row read through the one read port
// of the row store, border clamping of each row as it is latched, error, PD,
// FIR and speed, differential steering, then the output load; out_valid rises and
// the next item can be accepted in the cycle after that load.
// One item is in work at a time; in_stall is high from the cycle after a
// refresh is accepted until its result is loaded into the output register.
// Output channel (out_valid/out_stall): left_target, right_target,
// track_error, turn_value. While out_stall is high the result is held and
// a further refresh waits in its last step.
// Configuration (cfg_valid/cfg_ready, always ready): cfg_index 0..4 selects
// prop_gain, deriv_gain, steer_gain, left_border, right_border.
// Reset clears gains/borders to defaults and the error/PD/FIR history to zero;
// row store contents are undefined until written.
`default_nettype none
module line_follow_steering_pd
    import lfs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [6:0]  row,
    input  wire logic [7:0]  center_col,
    input  wire logic [9:0]  cruise_speed,
    input  wire logic [6:0]  aim_row,
    input  wire logic [6:0]  stop_line,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [10:0] left_target,
    output logic signed [10:0] right_target,
    output logic signed [17:0] track_error,
    output logic signed [23:0] turn_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    lfs_cmd_t cmd;

    assign cfg_ready = 1'b1;

    lfs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_action(action),
        .out_stall(out_stall), .in_stall(in_stall), .out_valid(out_valid),
        .cmd(cmd)
    );

    lfs_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .action(action), .row(row),
        .center_col(center_col), .cruise_speed(cruise_speed), .aim_row(aim_row),
        .stop_line(stop_line), .left_target(left_target),
        .right_target(right_target), .track_error(track_error),
        .turn_value(turn_value)
    );
endmodule
`default_nettype wire
